@@ hdl/dtpb_pkg.sv @@
// shared types, widths and register codes for the depth-to-point back-projection core
`timescale 1ns / 1ps

package dtpb_pkg;

   // item field widths
   localparam int DEPTH_W  = 16;
   localparam int COLOR_W  = 8;
   localparam int COORD_W  = 32;
   localparam int INDEX_W  = 24;

   // configuration register widths
   localparam int DIM_W    = 13;
   localparam int CENTER_W = 16;
   localparam int INV_W    = 24;

   // frame size limits in use, wide enough for the largest side
   localparam int LIM_W    = 14;
   localparam int MAX_SIDE_DEF = 4096;

   // packed channel widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 128;
   localparam int RSP_USER_W = 1;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_CENTER_X     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_CENTER_Y     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_INV_FOCAL_X  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_INV_FOCAL_Y  = 3'd5;

   // register reset values
   localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 13'd480;
   localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5112;
   localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3832;
   localparam logic [INV_W-1:0]    RST_INV_FOCAL_X  = 24'd31957;
   localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y  = 24'd31957;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [LIM_W-1:0]    last_col;
      logic [LIM_W-1:0]    last_row;
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
      logic [INV_W-1:0]    inv_x;
      logic [INV_W-1:0]    inv_y;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic mul_depth;
      logic mul_focal;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

@@ hdl/dtpb_csr.sv @@
// configuration registers and clamping of the frame size in use
`timescale 1ns / 1ps

module dtpb_csr #(
   parameter int MAX_SIDE = dtpb_pkg::MAX_SIDE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [dtpb_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dtpb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output dtpb_pkg::cfg_type                cfg
);
   import dtpb_pkg::*;

   localparam logic [LIM_W-1:0] SIDE_MAX = LIM_W'(MAX_SIDE);

   logic [DIM_W-1:0]    width_ff,  height_ff;
   logic [CENTER_W-1:0] cx_ff,     cy_ff;
   logic [INV_W-1:0]    ifx_ff,    ify_ff;
   logic [LIM_W-1:0]    width_use, height_use;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_FRAME_WIDTH;
         height_ff <= RST_FRAME_HEIGHT;
         cx_ff     <= RST_CENTER_X;
         cy_ff     <= RST_CENTER_Y;
         ifx_ff    <= RST_INV_FOCAL_X;
         ify_ff    <= RST_INV_FOCAL_Y;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            REG_CENTER_X:     cx_ff     <= csr_wdata[CENTER_W-1:0];
            REG_CENTER_Y:     cy_ff     <= csr_wdata[CENTER_W-1:0];
            REG_INV_FOCAL_X:  ifx_ff    <= csr_wdata[INV_W-1:0];
            REG_INV_FOCAL_Y:  ify_ff    <= csr_wdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp sizes to one through the largest side
   always_comb begin
      width_use  = LIM_W'(width_ff);
      height_use = LIM_W'(height_ff);
      if (width_ff == '0)
         width_use = LIM_W'(1);
      else if (width_use > SIDE_MAX)
         width_use = SIDE_MAX;
      if (height_ff == '0)
         height_use = LIM_W'(1);
      else if (height_use > SIDE_MAX)
         height_use = SIDE_MAX;
   end

   assign cfg.last_col = width_use - LIM_W'(1);
   assign cfg.last_row = height_use - LIM_W'(1);
   assign cfg.center_x = cx_ff;
   assign cfg.center_y = cy_ff;
   assign cfg.inv_x    = ifx_ff;
   assign cfg.inv_y    = ify_ff;

endmodule

@@ hdl/dtpb_ctrl.sv @@
// controller state machine sequencing one item through the datapath
`timescale 1ns / 1ps

module dtpb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  dtpb_pkg::status_type status,
   output dtpb_pkg::cmd_type    cmd
);
   import dtpb_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DEPTH = 2'd1;
   localparam logic [1:0] ST_FOCAL = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   logic [1:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.capture   = 1'b0;
      cmd.mul_depth = 1'b0;
      cmd.mul_focal = 1'b0;
      cmd.load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DEPTH;
            end
         end
         ST_DEPTH: begin
            cmd.mul_depth = 1'b1;
            state_in      = ST_FOCAL;
         end
         ST_FOCAL: begin
            cmd.mul_focal = 1'b1;
            state_in      = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/dtpb_datapath.sv @@
// pixel counters, offset and two-step multiply per axis, rounding, saturation, output register
`timescale 1ns / 1ps

module dtpb_datapath #(
   parameter int MAX_SIDE = dtpb_pkg::MAX_SIDE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dtpb_pkg::cfg_type                cfg,
   input  dtpb_pkg::cmd_type                cmd,
   output dtpb_pkg::status_type             status,
   input  logic [dtpb_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dtpb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [dtpb_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                             rsp_tlast
);
   import dtpb_pkg::*;

   localparam int CW  = $clog2(MAX_SIDE);
   localparam int PW  = (CW + 4 > CENTER_W) ? CW + 4 : CENTER_W;
   localparam int P1W = PW + DEPTH_W;
   localparam int P2W = P1W + INV_W;
   localparam int RW  = P2W - 23;
   localparam logic [P2W:0] RND = (P2W + 1)'(1) << 23;

   // counters
   logic [CW-1:0]      col_ff, col_in;
   logic [CW-1:0]      row_ff, row_in;
   logic [INDEX_W-1:0] cnt_ff, cnt_in;

   // captured item
   logic [DEPTH_W-1:0] z_ff;
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic               last_ff;
   logic [PW-1:0]      mag_x_ff, mag_y_ff;
   logic               neg_x_ff, neg_y_ff;
   logic [P1W-1:0]     p1_x_ff, p1_y_ff;
   logic [P2W-1:0]     p2_x_ff, p2_y_ff;

   // output register
   logic                   out_vld_ff;
   logic [RSP_DATA_W-1:0]  out_data_ff;
   logic                   out_user_ff;
   logic                   out_last_ff;

   logic [DEPTH_W-1:0] z_new;
   logic               row_end, frame_end, hit;
   logic [PW-1:0]      pos_x, pos_y, ctr_x, ctr_y;
   logic [COORD_W-1:0] x_res, y_res;

   // round half away from zero on the magnitude, then sign and saturate
   function automatic logic [COORD_W-1:0] round_sat(input logic neg,
                                                    input logic [P2W-1:0] prod);
      logic [P2W:0]  sum;
      logic [RW-1:0] r;
      logic          big;
      logic [COORD_W-1:0] res;
      sum = {1'b0, prod} + RND;
      r   = sum[P2W:24];
      big = |r[RW-1:COORD_W-1];
      if (neg)
         res = big ? {1'b1, {(COORD_W-1){1'b0}}} : (~r[COORD_W-1:0] + COORD_W'(1));
      else
         res = big ? {1'b0, {(COORD_W-1){1'b1}}} : r[COORD_W-1:0];
      return res;
   endfunction

   // raster position tests against the sizes in use
   assign z_new     = req_tdata[DEPTH_W-1:0];
   assign hit       = (z_new != '0);
   assign row_end   = ({{(LIM_W-CW){1'b0}}, col_ff} >= cfg.last_col);
   assign frame_end = row_end && ({{(LIM_W-CW){1'b0}}, row_ff} >= cfg.last_row);

   // pixel offsets in 1/16 pixel
   assign pos_x = PW'({col_ff, 4'b0000});
   assign pos_y = PW'({row_ff, 4'b0000});
   assign ctr_x = PW'(cfg.center_x);
   assign ctr_y = PW'(cfg.center_y);

   // counter advance
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cnt_in = cnt_ff;
      if (frame_end) begin
         col_in = '0;
         row_in = '0;
         cnt_in = '0;
      end else begin
         if (row_end) begin
            col_in = '0;
            row_in = row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
         if (hit)
            cnt_in = cnt_ff + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.capture) begin
         col_ff <= col_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
      end
   end

   // capture item and offsets
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         z_ff     <= z_new;
         red_ff   <= req_tdata[DEPTH_W +: COLOR_W];
         green_ff <= req_tdata[DEPTH_W+COLOR_W +: COLOR_W];
         blue_ff  <= req_tdata[DEPTH_W+2*COLOR_W +: COLOR_W];
         idx_ff   <= cnt_ff;
         last_ff  <= frame_end;
         neg_x_ff <= (pos_x < ctr_x);
         neg_y_ff <= (pos_y < ctr_y);
         mag_x_ff <= (pos_x < ctr_x) ? (ctr_x - pos_x) : (pos_x - ctr_x);
         mag_y_ff <= (pos_y < ctr_y) ? (ctr_y - pos_y) : (pos_y - ctr_y);
      end
   end

   // offset times depth
   always_ff @(posedge clock) begin
      if (cmd.mul_depth) begin
         p1_x_ff <= P1W'(mag_x_ff) * P1W'(z_ff);
         p1_y_ff <= P1W'(mag_y_ff) * P1W'(z_ff);
      end
   end

   // times reciprocal focal length
   always_ff @(posedge clock) begin
      if (cmd.mul_focal) begin
         p2_x_ff <= P2W'(p1_x_ff) * P2W'(cfg.inv_x);
         p2_y_ff <= P2W'(p1_y_ff) * P2W'(cfg.inv_y);
      end
   end

   assign x_res = round_sat(neg_x_ff, p2_x_ff);
   assign y_res = round_sat(neg_y_ff, p2_y_ff);

   // output register, free when empty or being taken
   assign status.out_free = !out_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_user_ff <= (z_ff != '0);
         out_last_ff <= last_ff;
         if (z_ff != '0)
            out_data_ff <= {idx_ff, blue_ff, green_ff, red_ff, z_ff, y_res, x_res};
         else
            out_data_ff <= '0;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ hdl/depth_to_point_backprojection_core.sv @@
// top level of the depth-to-point back-projection core
//
//   channel   dir  handshake                 payload
//   req_*     in   req_tvalid / req_tready   depth, red, green, blue
//   rsp_*     out  rsp_tvalid / rsp_tready   x, y, z, color, index; tuser valid; tlast
//   csr_*     in   csr_we                    csr_addr selects register, csr_wdata
//
// an item passes through four steps: capture with offsets, offset times depth,
// times reciprocal focal length, then rounding and saturation into the output register
// the next item is taken while a finished result waits in the output register;
// a stalled result holds the last step until the output register frees
// synchronous active-high reset returns counters to the first pixel and restores
// the register defaults
`timescale 1ns / 1ps

module depth_to_point_backprojection_core #(
   parameter int MAX_SIDE = dtpb_pkg::MAX_SIDE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // depth [15:0], red [23:16], green [31:24], blue [39:32]
   input  logic [dtpb_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // point_x [31:0], point_y [63:32], point_z [79:64], out_red [87:80],
   // out_green [95:88], out_blue [103:96], point_index [127:104]
   output logic [dtpb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // point_valid [0]
   output logic [dtpb_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                             rsp_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_we,
   input  logic [dtpb_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dtpb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dtpb_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // configuration registers
   dtpb_csr #(.MAX_SIDE(MAX_SIDE)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   dtpb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic and output register
   dtpb_datapath #(.MAX_SIDE(MAX_SIDE)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
